FILE: design/mwm_pkg.sv
package mwm_pkg;

  localparam int SQRT_STAGES     = 4;
  localparam int ITERS_PER_STAGE = 4;

  localparam logic [1:0] REG_TRANSLATION_GAIN = 2'd0;
  localparam logic [1:0] REG_ROTATION_GAIN    = 2'd1;
  localparam logic [1:0] REG_POWER_LIMIT      = 2'd2;

  localparam logic [6:0] TRANSLATION_GAIN_RESET = 7'd48;
  localparam logic [6:0] ROTATION_GAIN_RESET    = 7'd25;
  localparam logic [6:0] POWER_LIMIT_RESET      = 7'd100;

  // partial remainder and root of the digit-by-digit square root
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] res;
  } sqrt_t;

endpackage

FILE: design/mecanum_wheel_mixer.sv
// channel   direction  handshake          payload
// s_axis    in         s_tvalid/s_tready  s_tdata: horizontal, vertical, rotation
// m_axis    out        m_tvalid/m_tready  m_tdata: wheel_one .. wheel_four
// cfg       in         cfg_wr_en          cfg_index, cfg_data
//
// ten register stages: squares, sum, four square root stages, two multiply
// stages, wheel sums, truncate and saturate; one transfer per cycle unless the output stalls
// each stage moves on when it is empty or the stage after it moves, so bubbles
// close up and a stalled output holds only the stages behind it
// rst (synchronous) clears the stage valid bits and loads the register defaults
module mecanum_wheel_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // horizontal[15:0], vertical[31:16], rotation[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // wheel_one[7:0], wheel_two[15:8], wheel_three[23:16],
                                 // wheel_four[31:24]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int NSTG = 10;
  localparam int SQ0  = 2;
  localparam int MUL0 = SQ0 + mwm_pkg::SQRT_STAGES;

  logic [6:0] trans_gain;
  logic [6:0] rot_gain;
  logic [6:0] power_limit;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  logic signed [15:0] h_in, v_in, r_in;
  logic signed [31:0] prod_hh, prod_vv;

  logic signed [15:0] h_p [0:MUL0-1];
  logic signed [15:0] v_p [0:MUL0-1];
  logic signed [15:0] r_p [0:MUL0-1];
  logic [30:0] hh0, vv0;
  logic [31:0] sq1;

  mwm_pkg::sqrt_t sq_chain [0:mwm_pkg::SQRT_STAGES];
  logic [15:0] len;

  logic signed [32:0] prod_hl, prod_vl;
  logic signed [23:0] prod_rt;
  logic signed [31:0] hl6, vl6;
  logic signed [22:0] rt6, rt7;
  logic signed [39:0] prod_x, prod_y;
  logic signed [38:0] x7, y7;
  logic signed [41:0] xe, ye, te;
  logic signed [41:0] w1, w2, w3, w4;
  logic [7:0] out_w1, out_w2, out_w3, out_w4;

  function automatic logic [7:0] finish(input logic signed [41:0] s, input logic [6:0] lim);
    logic signed [41:0] adj;
    logic signed [12:0] q;
    logic signed [12:0] lm;
    logic signed [12:0] p;
    adj = s[41] ? (s + 42'sd1073741823) : s;
    q   = 13'(adj >>> 30);
    lm  = $signed({6'd0, lim});
    p   = q;
    if (q > lm) begin
      p = lm;
    end else if (q < -lm) begin
      p = -lm;
    end
    return p[7:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      trans_gain  <= mwm_pkg::TRANSLATION_GAIN_RESET;
      rot_gain    <= mwm_pkg::ROTATION_GAIN_RESET;
      power_limit <= mwm_pkg::POWER_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mwm_pkg::REG_TRANSLATION_GAIN: trans_gain  <= cfg_data;
        mwm_pkg::REG_ROTATION_GAIN:    rot_gain    <= cfg_data;
        mwm_pkg::REG_POWER_LIMIT:      power_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables, from the output back
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign h_in    = s_tdata[15:0];
  assign v_in    = s_tdata[31:16];
  assign r_in    = s_tdata[47:32];
  assign prod_hh = h_in * h_in;
  assign prod_vv = v_in * v_in;

  // squares, then their sum; axes ride along to the multiply stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      h_p[0] <= h_in;
      v_p[0] <= v_in;
      r_p[0] <= r_in;
      hh0    <= prod_hh[30:0];
      vv0    <= prod_vv[30:0];
    end
    if (en[1]) begin
      sq1 <= {1'b0, hh0} + {1'b0, vv0};
    end
    for (int k = 1; k < MUL0; k++) begin
      if (en[k]) begin
        h_p[k] <= h_p[k-1];
        v_p[k] <= v_p[k-1];
        r_p[k] <= r_p[k-1];
      end
    end
  end

  assign sq_chain[0] = '{rem: sq1, res: 32'd0};

  for (genvar g = 0; g < mwm_pkg::SQRT_STAGES; g++) begin : g_sqrt
    mwm_sqrt_stage #(
      .FIRST(g * mwm_pkg::ITERS_PER_STAGE)
    ) u_stage (
      .clk(clk),
      .en (en[SQ0+g]),
      .d  (sq_chain[g]),
      .q  (sq_chain[g+1])
    );
  end

  assign len = sq_chain[mwm_pkg::SQRT_STAGES].res[15:0];

  assign prod_hl = h_p[MUL0-1] * $signed({1'b0, len});
  assign prod_vl = v_p[MUL0-1] * $signed({1'b0, len});
  assign prod_rt = r_p[MUL0-1] * $signed({1'b0, rot_gain});
  assign prod_x  = hl6 * $signed({1'b0, trans_gain});
  assign prod_y  = vl6 * $signed({1'b0, trans_gain});

  assign xe = 42'(x7);
  assign ye = 42'(y7);
  assign te = {{4{rt7[22]}}, rt7, 15'd0};

  always_ff @(posedge clk) begin
    if (en[MUL0]) begin
      hl6 <= prod_hl[31:0];
      vl6 <= prod_vl[31:0];
      rt6 <= prod_rt[22:0];
    end
    if (en[MUL0+1]) begin
      x7  <= prod_x[38:0];
      y7  <= prod_y[38:0];
      rt7 <= rt6;
    end
    if (en[MUL0+2]) begin
      w1 <= ye - xe - te;
      w2 <= xe + ye + te;
      w3 <= xe + ye - te;
      w4 <= ye - xe + te;
    end
    if (en[MUL0+3]) begin
      out_w1 <= finish(w1, power_limit);
      out_w2 <= finish(w2, power_limit);
      out_w3 <= finish(w3, power_limit);
      out_w4 <= finish(w4, power_limit);
    end
  end

  assign m_tdata = {out_w4, out_w3, out_w2, out_w1};

endmodule

FILE: design/mwm_sqrt_stage.sv
module mwm_sqrt_stage #(
  parameter int FIRST = 0
) (
  input  logic          clk,
  input  logic          en,
  input  mwm_pkg::sqrt_t d,
  output mwm_pkg::sqrt_t q
);

  mwm_pkg::sqrt_t work;
  logic [32:0]    bit_w;
  logic [32:0]    trial;

  // four root digits per stage
  always_comb begin
    work  = d;
    bit_w = '0;
    trial = '0;
    for (int j = 0; j < mwm_pkg::ITERS_PER_STAGE; j++) begin
      bit_w = 33'd1 << (30 - 2 * (FIRST + j));
      trial = {1'b0, work.res} + bit_w;
      if ({1'b0, work.rem} >= trial) begin
        work.rem = work.rem - trial[31:0];
        work.res = (work.res >> 1) + bit_w[31:0];
      end else begin
        work.res = work.res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= work;
    end
  end

endmodule

FILE: tb/mecanum_wheel_mixer_tb.sv
`timescale 1ns / 100ps

module mecanum_wheel_mixer_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [15:0] rotation;
    logic [15:0] vertical;
    logic [15:0] horizontal;
  } joy_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = mwm_pkg::REG_TRANSLATION_GAIN;
  logic [6:0]  cfg_data = '0;

  logic [6:0] gain_xy = mwm_pkg::TRANSLATION_GAIN_RESET;
  logic [6:0] gain_turn = mwm_pkg::ROTATION_GAIN_RESET;
  logic [6:0] power_cap = mwm_pkg::POWER_LIMIT_RESET;

  joy_t        joy_q[$];
  logic [31:0] wheel_exp_q[$];
  string       wheel_name[4] = '{"wheel_one", "wheel_two", "wheel_three", "wheel_four"};

  int errors = 0;
  int cycle_count = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  mecanum_wheel_mixer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint floor_root(longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'sd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [7:0] clip_power(longint acc, longint lim);
    longint p;
    p = acc / Q30_ONE;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p[7:0];
  endfunction

  function automatic logic [31:0] mix_wheels(joy_t j);
    longint h, v, r, len, tg, rg, lim, x, y, t;
    h = $signed(j.horizontal);
    v = $signed(j.vertical);
    r = $signed(j.rotation);
    tg = gain_xy;
    rg = gain_turn;
    lim = power_cap;
    len = floor_root(h * h + v * v);
    x = h * len * tg;
    y = v * len * tg;
    t = r * rg * 32768;
    return {clip_power(-x + y + t, lim), clip_power(x + y - t, lim),
            clip_power(x + y + t, lim), clip_power(-x + y - t, lim)};
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  // input side: expectation on each accepted transfer, then load the next item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        wheel_exp_q.insert(wheel_exp_q.size(), mix_wheels(joy_t'(s_tdata)));
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0 && !quiet) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (joy_q.size() > 0) begin
          s_tdata <= joy_q.pop_front();
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 9);
    end
  end

  // result check
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (wheel_exp_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = wheel_exp_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_tdata[i*8 +: 8] !== want[i*8 +: 8]) begin
            $display("%0t: %s expected %0d actual %0d", $time, wheel_name[i],
                     $signed(want[i*8 +: 8]), $signed(m_tdata[i*8 +: 8]));
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      mwm_pkg::REG_TRANSLATION_GAIN: gain_xy = val;
      mwm_pkg::REG_ROTATION_GAIN:    gain_turn = val;
      mwm_pkg::REG_POWER_LIMIT:      power_cap = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [6:0] tg, logic [6:0] rg, logic [6:0] lim);
    write_reg(mwm_pkg::REG_TRANSLATION_GAIN, tg);
    write_reg(mwm_pkg::REG_ROTATION_GAIN, rg);
    write_reg(mwm_pkg::REG_POWER_LIMIT, lim);
  endtask

  task automatic queue_joy(logic [15:0] h, logic [15:0] v, logic [15:0] r);
    joy_t j;
    j.horizontal = h;
    j.vertical = v;
    j.rotation = r;
    joy_q.insert(joy_q.size(), j);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (joy_q.size() > 0 || s_tvalid || wheel_exp_q.size() > 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) queue_joy(pick_axis(), pick_axis(), pick_axis());
    wait_idle();
  endtask

  task automatic queue_directed();
    queue_joy(16'h0000, 16'h0000, 16'h0000);
    queue_joy(16'h7FFF, 16'h0000, 16'h0000);
    queue_joy(16'h8000, 16'h0000, 16'h0000);
    queue_joy(16'h0000, 16'h7FFF, 16'h0000);
    queue_joy(16'h0000, 16'h8000, 16'h0000);
    queue_joy(16'h0000, 16'h0000, 16'h7FFF);
    queue_joy(16'h0000, 16'h0000, 16'h8000);
    queue_joy(16'h8000, 16'h8000, 16'h8000);
    queue_joy(16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_joy(16'h8000, 16'h7FFF, 16'h0000);
    queue_joy(16'h7FFF, 16'h8000, 16'h7FFF);
    queue_joy(16'h0001, 16'hFFFF, 16'h0001);
    queue_joy(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_joy(16'h4000, 16'h4000, 16'hC000);
    queue_joy(16'h5A82, 16'hA57E, 16'h2000);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    wait_idle();
    set_gains(7'd127, 7'd127, 7'd127);
    queue_directed();
    wait_idle();
    set_gains(7'd0, 7'd127, 7'd0);
    queue_directed();
    wait_idle();

    // long stall on the output while items keep coming
    set_gains(mwm_pkg::TRANSLATION_GAIN_RESET, mwm_pkg::ROTATION_GAIN_RESET,
              mwm_pkg::POWER_LIMIT_RESET);
    hold_req = 1'b1;
    run_random(150);

    set_gains(7'd127, 7'd127, 7'd127);
    run_random(150);
    set_gains(7'd0, 7'd0, 7'd127);
    run_random(80);
    set_gains(7'd127, 7'd0, 7'd1);
    run_random(100);
    set_gains(7'd0, 7'd127, 7'd0);
    run_random(60);

    // writes to the unused index must not touch any register
    set_gains(7'd64, 7'd64, 7'd64);
    write_reg(REG_UNUSED, 7'h7F);
    write_reg(REG_UNUSED, 7'h00);
    run_random(100);

    repeat (4) begin
      set_gains(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
      run_random(130);
    end

    quiet = 1'b1;
    set_gains(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              7'($urandom_range(1, 127)));
    run_random(150);

    repeat (20) @(posedge clk);
    if (wheel_exp_q.size() > 0) begin
      $display("%0t: %0d transfers never arrived", $time, wheel_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
